@@ design/packed_sample_unpacker_core_defines.svh @@
// Assertion macros used by the port-level checker of the sample unpacker.
// Depends on nothing; expects a clock i_clk and a reset i_rst_n in scope.
`ifndef PACKED_SAMPLE_UNPACKER_CORE_DEFINES_SVH
`define PACKED_SAMPLE_UNPACKER_CORE_DEFINES_SVH

// Property checked only while out of reset
`define PSU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define PSU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ design/psu_pkg.sv @@
// Shared types and constants of the packed sample unpacker.
// No dependencies; used by the core and its checker.
package psu_pkg;

    // Default number of sample planes
    localparam int MAX_PLANES_DEF = 8;

    // Field widths
    localparam int DEPTH_W  = 7;
    localparam int BYTE_W   = 8;
    localparam int PLANE_W  = 3;
    localparam int SAMPLE_W = 32;
    localparam int LEFT_W   = 4;
    localparam int POS_W    = 8;

    // Assembly constants
    localparam int BYTE_BITS    = 8;
    localparam int HIGH_BASE    = 24;
    localparam int WORD_BITS    = 32;
    localparam int MSB_MODE_LIM = 16;

    // Depth after reset
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 7'd8;

    // Request kinds carried in the low tuser bit
    localparam logic REQ_DATA    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

endpackage

@@ design/packed_sample_unpacker_core.sv @@
// Packed sample unpacker core: per-plane bit gathering into samples of 1 to 127 bits.
// Depends on psu_pkg for widths, constants and the state type.
//
// The core takes one byte per item together with its plane, and returns every
// sample that the byte completes, 0 to 8 of them, the final one flagged on tlast.
// Per-plane partial sample and bit count live in a small synchronous memory,
// read when the item is taken and written back when its byte is used up. An
// item is accepted in IDLE together with the state read, then worked off in RUN
// one chunk of the byte per cycle (a chunk ends at a sample boundary or the byte
// end) while the output is not held off. Restart items and configuration writes
// are taken in IDLE and clear every plane at once through a valid bit per plane,
// so no clearing pass runs after reset.
module packed_sample_unpacker_core #(
    parameter int MAX_PLANES = psu_pkg::MAX_PLANES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: sample_depth
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data,     // [6:0] sample_depth
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [3:0]  s_axis_tuser,   // [0] req_type, [3:1] plane_index
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sample_value
    output logic [2:0]  m_axis_tuser,   // [2:0] sample_plane
    output logic        m_axis_tlast    // last_of_byte
);

    localparam int AW    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int ENT_W = psu_pkg::SAMPLE_W + psu_pkg::DEPTH_W;

    // Control registers
    psu_pkg::t_state                  r_state, n_state;
    logic [psu_pkg::DEPTH_W-1:0]      r_depth;
    logic [MAX_PLANES-1:0]            r_vld;
    logic                             r_first;
    logic                             r_rd_vld;
    logic                             r_out_valid;

    // Payload registers
    logic [psu_pkg::BYTE_W-1:0]       r_byte;
    logic [psu_pkg::PLANE_W-1:0]      r_plane;
    logic [psu_pkg::LEFT_W-1:0]       r_left;
    logic [psu_pkg::SAMPLE_W-1:0]     r_val;
    logic [psu_pkg::DEPTH_W-1:0]      r_need;
    logic [ENT_W-1:0]                 r_rd_data;
    logic [psu_pkg::SAMPLE_W-1:0]     r_out_val;
    logic [psu_pkg::PLANE_W-1:0]      r_out_plane;
    logic                             r_out_last;

    // Plane state memory: {bits_remaining, partial_sample}
    logic [ENT_W-1:0]                 mem [MAX_PLANES];

    logic                             w_s_acc, w_cfg_acc, w_in_range, w_rd_en;
    logic [psu_pkg::PLANE_W-1:0]      w_in_plane;
    logic [AW-1:0]                    w_rd_addr, w_wr_addr;
    logic [psu_pkg::DEPTH_W-1:0]      w_eff_depth, w_need_raw, w_need, w_need_n;
    logic [psu_pkg::SAMPLE_W-1:0]     w_val, w_val_n, w_placed, w_chunk32;
    logic [psu_pkg::LEFT_W-1:0]       w_t, w_left_n;
    logic [psu_pkg::BYTE_W-1:0]       w_shifted, w_mask, w_chunk;
    logic signed [psu_pkg::POS_W-1:0] w_pos;
    logic [psu_pkg::POS_W-1:0]        w_neg;
    logic                             w_keep, w_emit, w_last, w_step, w_done;
    logic [psu_pkg::SAMPLE_W-1:0]     w_val_after;
    logic [psu_pkg::DEPTH_W-1:0]      w_need_after;

    // Handshakes
    assign s_axis_tready = (r_state == psu_pkg::ST_IDLE);
    assign o_cfg_ready   = (r_state == psu_pkg::ST_IDLE);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign w_cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign w_in_plane    = s_axis_tuser[3:1];
    assign w_in_range    = (32'(w_in_plane) < MAX_PLANES);
    assign w_rd_en       = w_s_acc && (s_axis_tuser[0] == psu_pkg::REQ_DATA) && w_in_range;
    assign w_rd_addr     = AW'(w_in_plane);
    assign w_wr_addr     = AW'(r_plane);

    // Depth zero behaves as depth one
    assign w_eff_depth = (r_depth == '0) ? psu_pkg::DEPTH_W'(1) : r_depth;

    // Take fresh plane state on the first chunk, else the working registers
    always_comb begin
        if (r_first) begin
            w_val      = r_rd_vld ? r_rd_data[psu_pkg::SAMPLE_W-1:0] : '0;
            w_need_raw = r_rd_vld ? r_rd_data[ENT_W-1:psu_pkg::SAMPLE_W] : '0;
        end else begin
            w_val      = r_val;
            w_need_raw = r_need;
        end
        w_need = (w_need_raw == '0) ? w_eff_depth : w_need_raw;
    end

    // Cut one chunk off the byte, most significant bits first
    always_comb begin
        w_t       = (w_need < psu_pkg::DEPTH_W'(r_left)) ? w_need[psu_pkg::LEFT_W-1:0] : r_left;
        w_need_n  = w_need - psu_pkg::DEPTH_W'(w_t);
        w_left_n  = r_left - w_t;
        w_shifted = r_byte >> w_left_n;
        w_mask    = psu_pkg::BYTE_W'((9'd1 << w_t) - 9'd1);
        w_chunk   = w_shifted & w_mask;
        w_chunk32 = psu_pkg::SAMPLE_W'(w_chunk);
    end

    // Place the chunk according to the assembly mode
    always_comb begin
        w_keep = 1'b1;
        if (w_eff_depth <= psu_pkg::DEPTH_W'(psu_pkg::WORD_BITS)) begin
            w_pos = psu_pkg::POS_W'(w_eff_depth) - psu_pkg::POS_W'(psu_pkg::BYTE_BITS)
                    - psu_pkg::POS_W'(w_need_n);
        end else begin
            w_keep = (w_need_n < psu_pkg::DEPTH_W'(psu_pkg::WORD_BITS));
            w_pos  = psu_pkg::POS_W'(psu_pkg::HIGH_BASE) - psu_pkg::POS_W'(w_need_n);
        end
        w_neg = psu_pkg::POS_W'(-w_pos);
        if (w_pos >= 0) begin
            w_placed = w_chunk32 << w_pos[4:0];
        end else begin
            w_placed = w_chunk32 >> w_neg[4:0];
        end
        if (w_eff_depth < psu_pkg::DEPTH_W'(psu_pkg::MSB_MODE_LIM)) begin
            w_val_n = (w_val << w_t) | w_chunk32;
        end else if (w_keep) begin
            w_val_n = w_val | w_placed;
        end else begin
            w_val_n = w_val;
        end
    end

    // Sample completion and end of byte
    always_comb begin
        w_emit       = (w_need_n == '0);
        w_last       = (w_left_n == '0) || (psu_pkg::DEPTH_W'(w_left_n) < w_eff_depth);
        w_step       = (r_state == psu_pkg::ST_RUN) && (!r_out_valid || m_axis_tready);
        w_done       = w_step && (w_left_n == '0);
        w_val_after  = w_emit ? '0 : w_val_n;
        w_need_after = w_emit ? w_eff_depth : w_need_n;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psu_pkg::ST_IDLE: begin
                if (w_rd_en) begin
                    n_state = psu_pkg::ST_RUN;
                end
            end
            psu_pkg::ST_RUN: begin
                if (w_done) begin
                    n_state = psu_pkg::ST_IDLE;
                end
            end
            default: n_state = psu_pkg::ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psu_pkg::ST_IDLE;
            r_depth     <= psu_pkg::DEPTH_RESET;
            r_vld       <= '0;
            r_first     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Apply depth and restart every plane; mark a plane valid when its byte is done
            if (w_cfg_acc) begin
                r_depth <= i_cfg_data;
                r_vld   <= '0;
            end else if (w_s_acc && (s_axis_tuser[0] == psu_pkg::REQ_RESTART)) begin
                r_vld <= '0;
            end else if (w_done) begin
                r_vld[w_wr_addr] <= 1'b1;
            end
            // A depth write taken with the byte clears the plane ahead of it
            if (w_rd_en) begin
                r_first  <= 1'b1;
                r_rd_vld <= r_vld[w_rd_addr] && !w_cfg_acc;
            end else if (w_step) begin
                r_first <= 1'b0;
            end
            // Hold the result until taken
            if (w_step && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and result payload
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_byte  <= s_axis_tdata;
            r_plane <= w_in_plane;
            r_left  <= psu_pkg::LEFT_W'(psu_pkg::BYTE_BITS);
        end else if (w_step) begin
            r_left <= w_left_n;
            r_val  <= w_val_after;
            r_need <= w_need_after;
        end
        if (w_step && w_emit) begin
            r_out_val   <= w_val_n;
            r_out_plane <= r_plane;
            r_out_last  <= w_last;
        end
    end

    // Plane state memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            mem[w_wr_addr] <= {w_need_after, w_val_after};
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_rd_addr];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_val;
    assign m_axis_tuser  = r_out_plane;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ design/psu_checker.sv @@
// Port-level checker for the packed sample unpacker core, bound into the core.
// Depends on psu_pkg and packed_sample_unpacker_core_defines.svh.
`include "packed_sample_unpacker_core_defines.svh"

module psu_checker #(
    parameter int MAX_PLANES = psu_pkg::MAX_PLANES_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_cfg_ready,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [3:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic w_data_acc, w_restart_acc, w_out_stall;

    // Classify accepted items
    assign w_data_acc = s_axis_tvalid && s_axis_tready
                        && (s_axis_tuser[0] == psu_pkg::REQ_DATA)
                        && (32'(s_axis_tuser[3:1]) < MAX_PLANES);
    assign w_restart_acc = s_axis_tvalid && s_axis_tready
                           && (s_axis_tuser[0] == psu_pkg::REQ_RESTART);
    assign w_out_stall = m_axis_tvalid && !m_axis_tready;

    // A stalled result holds
    `PSU_ASSERT(a_out_hold, w_out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    // A data byte leaves the core busy in the cycle after it is taken
    `PSU_ASSERT(a_data_busy, w_data_acc |=> !s_axis_tready, "data item without busy cycle")
    // A restart leaves the core free to take the next item
    `PSU_ASSERT(a_restart_idle, w_restart_acc |=> s_axis_tready, "restart did not return to idle")
    // Configuration and input sides open together
    `PSU_ASSERT(a_ready_match, o_cfg_ready == s_axis_tready, "config and input ready disagree")
    // No result straight out of reset
    `PSU_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind packed_sample_unpacker_core psu_checker #(
    .MAX_PLANES (MAX_PLANES)
) u_psu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_cfg_ready   (o_cfg_ready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ bench/tb_packed_sample_unpacker_core.sv @@
// Testbench of packed_sample_unpacker_core: directed and random byte streams per plane.
// Depends on psu_pkg and the core; predicts every sample in its own unpacking model.
`timescale 1ns / 100ps

module tb_packed_sample_unpacker_core;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_PLANES    = psu_pkg::MAX_PLANES_DEF;

    // One expected or observed sample
    typedef struct packed {
        logic [psu_pkg::SAMPLE_W-1:0] value;
        logic [psu_pkg::PLANE_W-1:0]  plane;
        logic                         last;
    } t_sample;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [psu_pkg::DEPTH_W-1:0]  i_cfg_data;       // [6:0] sample_depth
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [7:0]                   s_axis_tdata;     // [7:0] data_byte
    logic [3:0]                   s_axis_tuser;     // [0] req_type, [3:1] plane_index
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [31:0]                  m_axis_tdata;     // [31:0] sample_value
    logic [2:0]                   m_axis_tuser;     // [2:0] sample_plane
    logic                         m_axis_tlast;     // last_of_byte

    // Model state: depth register and per-plane gathering
    logic [psu_pkg::DEPTH_W-1:0]  depth_reg;
    logic [psu_pkg::SAMPLE_W-1:0] plane_acc [NUM_PLANES];
    logic [psu_pkg::DEPTH_W-1:0]  plane_need [NUM_PLANES];
    t_sample                      expected_samples [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int mismatches;
    int items_in;
    int samples_seen;
    int restarts_in;
    int depth_writes;

    packed_sample_unpacker_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Depth zero behaves as depth one
    function automatic int unsigned active_depth();
        return (depth_reg == '0) ? 1 : int'(depth_reg);
    endfunction

    function automatic void clear_planes();
        for (int i = 0; i < NUM_PLANES; i++) begin
            plane_acc[i]  = '0;
            plane_need[i] = psu_pkg::DEPTH_W'(active_depth());
        end
    endfunction

    // Shift left for a positive bit position, right (losing low bits) for a negative one
    function automatic logic [psu_pkg::SAMPLE_W-1:0] place_chunk(
        logic [psu_pkg::SAMPLE_W-1:0] chunk, int pos);
        if (pos >= 0)
            return chunk << pos;
        return chunk >> (-pos);
    endfunction

    // Consume one byte MSB first into a plane and queue each sample it completes
    function automatic void unpack_byte(logic [7:0] data,
                                        logic [psu_pkg::PLANE_W-1:0] plane_sel);
        int unsigned                  depth_eff;
        int unsigned                  need;
        int unsigned                  left;
        int unsigned                  take;
        logic [psu_pkg::SAMPLE_W-1:0] acc;
        logic [psu_pkg::SAMPLE_W-1:0] chunk;
        t_sample                      held;
        bit                           have_held;
        depth_eff = active_depth();
        need      = plane_need[plane_sel];
        if (need == 0)
            need = depth_eff;
        acc       = plane_acc[plane_sel];
        left      = psu_pkg::BYTE_BITS;
        have_held = 1'b0;
        held      = '0;
        while (left > 0) begin
            take  = (need < left) ? need : left;
            need -= take;
            left -= take;
            chunk = (psu_pkg::SAMPLE_W'(data) >> left) & ((32'd1 << take) - 32'd1);
            if (depth_eff < psu_pkg::MSB_MODE_LIM) begin
                acc = (acc << take) | chunk;
            end else if (depth_eff <= psu_pkg::WORD_BITS) begin
                acc |= place_chunk(chunk,
                                   int'(depth_eff) - psu_pkg::BYTE_BITS - int'(need));
            end else if (need < psu_pkg::WORD_BITS) begin
                acc |= place_chunk(chunk, psu_pkg::HIGH_BASE - int'(need));
            end
            if (need == 0) begin
                // hold the newest sample back so the final one can be flagged
                if (have_held)
                    expected_samples.push_back(held);
                held.value = acc;
                held.plane = plane_sel;
                held.last  = 1'b0;
                have_held  = 1'b1;
                acc        = '0;
                need       = depth_eff;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            expected_samples.push_back(held);
        end
        plane_acc[plane_sel]  = acc;
        plane_need[plane_sel] = psu_pkg::DEPTH_W'(need);
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // Track accepted items and register writes in the model
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            depth_reg = psu_pkg::DEPTH_RESET;
            clear_planes();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                depth_reg = i_cfg_data;
                clear_planes();
            end
            if (s_axis_tvalid && s_axis_tready) begin
                items_in++;
                if (s_axis_tuser[0] == psu_pkg::REQ_RESTART) begin
                    restarts_in++;
                    clear_planes();
                end else begin
                    unpack_byte(s_axis_tdata, s_axis_tuser[3:1]);
                end
            end
        end
    end

    // Compare each accepted sample with the oldest expectation
    always @(posedge i_clk) begin
        t_sample got;
        t_sample want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
            samples_seen++;
            if (expected_samples.size() == 0) begin
                note_mismatch($sformatf("Unexpected sample: value %h plane %0d last %0b",
                                        got.value, got.plane, got.last));
            end else begin
                want = expected_samples.pop_front();
                if (got.value != want.value || got.plane != want.plane
                        || got.last != want.last)
                    note_mismatch($sformatf(
                        "Mismatch: exp %h plane %0d last %0b, got %h plane %0d last %0b",
                        want.value, want.plane, want.last, got.value, got.plane, got.last));
            end
        end
    end

    // Receiver stalls
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Drive one item and hold it until accepted; tvalid stays high on return
    task automatic send_item(logic req, logic [7:0] data,
                             logic [psu_pkg::PLANE_W-1:0] plane_sel);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= {plane_sel, req};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every expected sample is out and the core is quiet
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_depth(logic [psu_pkg::DEPTH_W-1:0] depth);
        settle_block();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= depth;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        depth_writes++;
    endtask

    // Reset depth of 8: byte extremes on the outer planes, two bytes on plane 3, then a restart
    task automatic test_default_depth();
        send_item(psu_pkg::REQ_DATA, 8'h00, 3'd0);
        send_item(psu_pkg::REQ_DATA, 8'hFF, 3'd7);
        send_item(psu_pkg::REQ_DATA, 8'hA5, 3'd3);
        send_item(psu_pkg::REQ_DATA, 8'h5A, 3'd3);
        send_item(psu_pkg::REQ_RESTART, 8'hFF, 3'd7);
    endtask

    // MSB-first mode: depth one, depth zero, widest depth of the mode
    task automatic test_msb_mode();
        write_depth(7'd1);
        send_item(psu_pkg::REQ_DATA, 8'hFF, 3'd7);
        write_depth(7'd0);
        send_item(psu_pkg::REQ_DATA, 8'h81, 3'd0);
        write_depth(7'd15);
        send_item(psu_pkg::REQ_DATA, 8'hFF, 3'd1);
        send_item(psu_pkg::REQ_DATA, 8'h00, 3'd1);
    endtask

    // Byte-assembly mode, including a depth that places chunks at negative positions
    task automatic test_byte_mode();
        write_depth(7'd16);
        send_item(psu_pkg::REQ_DATA, 8'h34, 3'd2);
        send_item(psu_pkg::REQ_DATA, 8'h12, 3'd2);
        write_depth(7'd20);
        repeat (3) send_item(psu_pkg::REQ_DATA, 8'hFF, 3'd5);
        write_depth(7'd32);
        send_item(psu_pkg::REQ_DATA, 8'h01, 3'd6);
        send_item(psu_pkg::REQ_DATA, 8'h80, 3'd6);
        send_item(psu_pkg::REQ_DATA, 8'h55, 3'd6);
        send_item(psu_pkg::REQ_DATA, 8'hFE, 3'd6);
    endtask

    // Wide mode: only the last four bytes of a 64-bit sample survive
    task automatic test_wide_mode();
        write_depth(7'd64);
        for (int i = 0; i < 8; i++)
            send_item(psu_pkg::REQ_DATA, 8'(8'h11 * i + (i % 2 ? 8'h80 : 8'h00)), 3'd4);
    endtask

    // Random depths, each followed by a run of bytes on a few planes with stray items
    task automatic test_random(int tx_pct, int rx_pct, int num_items);
        int unsigned                 sent;
        int unsigned                 run_len;
        int unsigned                 pool;
        int unsigned                 base;
        int unsigned                 pick;
        logic [psu_pkg::DEPTH_W-1:0] depth;
        logic [7:0]                  data;
        int                          corner_depths [9] = '{1, 7, 8, 15, 16, 24, 32, 33, 64};
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < num_items) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                case ($urandom_range(2))
                    0:       depth = 7'd0;
                    1:       depth = 7'd127;
                    default: depth = psu_pkg::DEPTH_W'($urandom_range(65, 126));
                endcase
            end else if (pick < 30) begin
                depth = psu_pkg::DEPTH_W'(corner_depths[$urandom_range(8)]);
            end else begin
                depth = psu_pkg::DEPTH_W'($urandom_range(1, 64));
            end
            write_depth(depth);
            // keep wide samples on few planes so they complete
            pool    = (depth > psu_pkg::WORD_BITS) ? $urandom_range(1, 2)
                                                   : $urandom_range(1, NUM_PLANES);
            base    = $urandom_range(NUM_PLANES - 1);
            run_len = $urandom_range(8, 28);
            while (run_len > 0 && sent < num_items) begin
                pick = $urandom_range(99);
                data = 8'($urandom);
                if (pick < 4)
                    send_item(psu_pkg::REQ_RESTART, data, psu_pkg::PLANE_W'($urandom));
                else if (pick < 12)
                    send_item(psu_pkg::REQ_DATA, data,
                              psu_pkg::PLANE_W'($urandom_range(NUM_PLANES - 1)));
                else
                    send_item(psu_pkg::REQ_DATA, data,
                              psu_pkg::PLANE_W'((base + $urandom_range(pool - 1))
                                                % NUM_PLANES));
                run_len--;
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        tx_idle_pct   = 8;
        rx_idle_pct   = 84;
        mismatches    = 0;
        items_in      = 0;
        samples_seen  = 0;
        restarts_in   = 0;
        depth_writes  = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_depth();
        test_msb_mode();
        test_byte_mode();
        test_wide_mode();
        test_random(8, 84, 107);
        test_random(84, 8, 107);
        test_random(0, 0, 106);
        settle_block();

        $display("Run covered %0d items (%0d restarts), %0d samples checked, %0d depth writes",
                 items_in, restarts_in, samples_seen, depth_writes);
        $display("Depths swept over all three assembly modes, zero and above 64 included");
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("Mismatches: %0d, samples still expected: %0d",
                     mismatches, expected_samples.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
